>>> rtl/core/isqrt_pkg.sv
// ----------------------------------------------------------------------------
// isqrt_pkg
// Shared types and constants for the integer square root block.
// ----------------------------------------------------------------------------
package isqrt_pkg;

  localparam int INPUT_BITS_DEF = 64;
  localparam int RADICAND_W     = 64;
  localparam int ROOT_W         = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } isqrt_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } isqrt_cmd_t;

endpackage

>>> rtl/core/integer_square_root_top.sv
// ----------------------------------------------------------------------------
// integer_square_root_top
// Floor of the square root of a signed radicand, one result bit per round.
// ----------------------------------------------------------------------------
//  channel   ports                                  direction
//  input     in_valid, in_ready, in_radicand[63:0]  item in
//  result    out_valid, out_ready, out_root[31:0]   item out
//
// An item is loaded on acceptance, then runs its rounds, one trial
// subtraction each, and is then published to the result register.
// A new item is accepted in the cycle its predecessor moves to the result
// register, so no item is taken while another is still in its rounds.
// A stalled result holds the finished root inside until the register frees.
// Reset is synchronous and active low and leaves the block idle.
// ----------------------------------------------------------------------------
module integer_square_root_top
  import isqrt_pkg::*;
#(
  parameter int INPUT_BITS = INPUT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [RADICAND_W-1:0] in_radicand,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROOT_W-1:0]     out_root
);

  isqrt_cmd_t cmd;

  isqrt_ctrl #(
    .INPUT_BITS (INPUT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  isqrt_dp #(
    .INPUT_BITS (INPUT_BITS)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .radicand (in_radicand),
    .root     (out_root)
  );

endmodule

>>> rtl/core/isqrt_ctrl.sv
// ----------------------------------------------------------------------------
// isqrt_ctrl
// Sequencer for the root rounds and the handshakes on both channels.
// ----------------------------------------------------------------------------
module isqrt_ctrl
  import isqrt_pkg::*;
#(
  parameter int INPUT_BITS = INPUT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output isqrt_cmd_t cmd
);

  localparam int ROUNDS = (INPUT_BITS - 2) / 2 + 1;
  localparam int CNT_W  = $clog2(ROUNDS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ROUNDS - 1);

  isqrt_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             can_pub;

  assign can_pub   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (cnt_r == LAST_CNT) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (can_pub) begin
          cmd.publish = 1'b1;
          in_ready    = 1'b1;
          if (in_valid) begin
            cmd.load  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.publish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

  a_drop_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(out_valid_r) && $past(rst_n)) |-> $past(out_ready))
    else $error("result dropped without being taken");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_RUN && cnt_r == '0))
    else $error("accepted item did not start the rounds");

  a_rounds_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && cnt_r != LAST_CNT) |=> state_r == ST_RUN)
    else $error("round sequence ended early");
`endif

endmodule

>>> rtl/core/isqrt_dp.sv
// ----------------------------------------------------------------------------
// isqrt_dp
// Remainder, partial root and bit weight registers with one trial
// subtraction per round, plus the result register.
// ----------------------------------------------------------------------------
module isqrt_dp
  import isqrt_pkg::*;
#(
  parameter int INPUT_BITS = INPUT_BITS_DEF
) (
  input  logic                  clk,
  input  isqrt_cmd_t            cmd,
  input  logic [RADICAND_W-1:0] radicand,
  output logic [ROOT_W-1:0]     root
);

  localparam int W  = INPUT_BITS - 1;
  localparam int SH = ((INPUT_BITS - 2) / 2) * 2;

  logic [W-1:0] rem_r, rem_nxt;
  logic [W:0]   proot_r, proot_nxt;
  logic [W-1:0] wt_r, wt_nxt;
  logic [ROOT_W-1:0] root_r;

  logic [INPUT_BITS-1:0] value;
  logic [W:0]            trial;
  logic [W:0]            grown;

  assign value = radicand[INPUT_BITS-1:0];
  assign trial = proot_r + {1'b0, wt_r};
  assign grown = trial + {1'b0, wt_r};
  assign root  = root_r;

  always_comb begin
    rem_nxt   = rem_r;
    proot_nxt = proot_r;
    wt_nxt    = wt_r;
    if (cmd.load) begin
      rem_nxt   = value[INPUT_BITS-1] ? '0 : value[W-1:0];
      proot_nxt = '0;
      wt_nxt    = W'(1) << SH;
    end else if (cmd.step) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt   = rem_r - trial[W-1:0];
        proot_nxt = grown >> 1;
      end else begin
        proot_nxt = proot_r >> 1;
      end
      wt_nxt = wt_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    proot_r <= proot_nxt;
    wt_r    <= wt_nxt;
    if (cmd.publish) begin
      root_r <= ROOT_W'(proot_r);
    end
  end

endmodule
